/* design/ppe_pkg.sv */
// ----------------------------------------------------------------------------
// Palette pixel expander package
// Shared constants: register map, display modes, reset values and geometry.
// ----------------------------------------------------------------------------
package ppe_pkg;

  // Palette depth and source width limit.
  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_FRAME_WIDTH = 320;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DISPLAY_MODE = 3'd0;
  localparam logic [2:0] REG_LINE_DOUBLE  = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [2:0] REG_SCREEN_PITCH = 3'd4;

  // Display modes. Code three behaves like the 800x480 mode.
  localparam logic [1:0] MODE_VGA_32  = 2'd0;
  localparam logic [1:0] MODE_QVGA_16 = 2'd1;
  localparam logic [1:0] MODE_WVGA_16 = 2'd2;

  // Register reset values.
  localparam logic [8:0]  RST_FRAME_WIDTH  = 9'd320;
  localparam logic [7:0]  RST_FRAME_HEIGHT = 8'd240;
  localparam logic [10:0] RST_SCREEN_PITCH = 11'd640;

  // Screen geometry used for centering.
  localparam logic [10:0] SCREEN_ROWS   = 11'd240;
  localparam logic [8:0]  CENTER_NARROW = 9'd320;
  localparam logic [8:0]  CENTER_WIDE   = 9'd400;

endpackage

/* design/palette_pixel_expander.sv */
// ----------------------------------------------------------------------------
// Palette pixel expander
// Looks indexed source pixels up in a 256-entry palette and writes them to a
// centered screen as BGRA8888 or RGB565 words, doubled per display mode and line doubling.
// ----------------------------------------------------------------------------
// The first screen word of a pixel is presented once the pixel has passed
// the stage A, stage B and output word registers. A pixel makes 1, 2, 4 or
// 8 screen words, one word per cycle while m_axis_tready is high; the next
// pixel enters the output word register once the last word is taken. Palette
// writes make no words. Reset sets the configuration to its reset values and
// at once clears the counters and palette valid bits; no clearing pass.
module palette_pixel_expander
  import ppe_pkg::*;
#(
  parameter int PaletteEntries = PALETTE_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Source words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: color_index[7:0], red[15:8], green[23:16], blue[31:24],
  //        pixel_value[39:32]
  input  logic [39:0] s_axis_tdata,
  // tuser: req_type[0]
  input  logic        s_axis_tuser,
  // Screen writes.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: pixel_word[31:0], dest_index[50:32], zero fill[55:51]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdxW = (PaletteEntries > 1) ? $clog2(PaletteEntries) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]  cfg_mode_q;
  logic        cfg_dbl_q;
  logic [8:0]  cfg_width_q;
  logic [7:0]  cfg_height_q;
  logic [10:0] cfg_pitch_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q   <= MODE_VGA_32;
      cfg_dbl_q    <= 1'b0;
      cfg_width_q  <= RST_FRAME_WIDTH;
      cfg_height_q <= RST_FRAME_HEIGHT;
      cfg_pitch_q  <= RST_SCREEN_PITCH;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_DISPLAY_MODE: cfg_mode_q   <= pwdata[1:0];
        REG_LINE_DOUBLE:  cfg_dbl_q    <= pwdata[0];
        REG_FRAME_WIDTH:  cfg_width_q  <= pwdata[8:0];
        REG_FRAME_HEIGHT: cfg_height_q <= pwdata[7:0];
        REG_SCREEN_PITCH: cfg_pitch_q  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DISPLAY_MODE: prdata = {30'd0, cfg_mode_q};
      REG_LINE_DOUBLE:  prdata = {31'd0, cfg_dbl_q};
      REG_FRAME_WIDTH:  prdata = {23'd0, cfg_width_q};
      REG_FRAME_HEIGHT: prdata = {24'd0, cfg_height_q};
      REG_SCREEN_PITCH: prdata = {21'd0, cfg_pitch_q};
      default:          prdata = 32'd0;
    endcase
  end

  // Derived configuration.
  logic [8:0] eff_width;
  logic       mode_one;
  logic       mode_bgra;
  logic [8:0] center;

  assign eff_width = ({2'b00, cfg_width_q} > 11'(MAX_FRAME_WIDTH)) ?
                     9'(MAX_FRAME_WIDTH) : cfg_width_q;
  assign mode_one  = (cfg_mode_q == MODE_QVGA_16);
  assign mode_bgra = (cfg_mode_q == MODE_VGA_32);
  assign center    = (mode_one || mode_bgra) ? CENTER_NARROW : CENTER_WIDE;

  // --------------------------------------------------------------------------
  // Handshake of the pipeline
  // --------------------------------------------------------------------------
  logic a_v_q, b_v_q, c_v_q;
  logic a_ready, b_ready, c_ready;
  logic [2:0] c_cnt_q;
  logic s_acc, pix_acc, pal_acc;

  assign c_ready = !c_v_q || (m_axis_tready && (c_cnt_q == 3'd0));
  assign b_ready = !b_v_q || c_ready;
  assign a_ready = !a_v_q || b_ready;

  assign s_axis_tready = a_ready;
  assign s_acc   = s_axis_tvalid & s_axis_tready;
  assign pix_acc = s_acc & s_axis_tuser;
  assign pal_acc = s_acc & ~s_axis_tuser;

  // --------------------------------------------------------------------------
  // Palette store with per-entry valid bits
  // --------------------------------------------------------------------------
  logic [23:0]               pal_mem [PaletteEntries];
  logic [PaletteEntries-1:0] pal_vld_q;
  logic [7:0]                wr_idx, rd_idx;
  logic                      wr_in_range, rd_in_range;
  logic [23:0]               a_rgb_q;
  logic                      a_hit_q;

  assign wr_idx      = s_axis_tdata[7:0];
  assign rd_idx      = s_axis_tdata[39:32];
  assign wr_in_range = ({1'b0, wr_idx} < 9'(PaletteEntries));
  assign rd_in_range = ({1'b0, rd_idx} < 9'(PaletteEntries));

  always_ff @(posedge clk_i) begin
    if (pal_acc && wr_in_range) begin
      pal_mem[wr_idx[IdxW-1:0]] <= {s_axis_tdata[15:8], s_axis_tdata[23:16],
                                    s_axis_tdata[31:24]};
    end
    if (pix_acc) begin
      a_rgb_q <= pal_mem[rd_idx[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
      a_hit_q   <= 1'b0;
    end else begin
      if (pal_acc && wr_in_range) begin
        pal_vld_q[wr_idx[IdxW-1:0]] <= 1'b1;
      end
      if (pix_acc) begin
        a_hit_q <= rd_in_range && pal_vld_q[rd_idx[IdxW-1:0]];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Raster counters and stage A
  // --------------------------------------------------------------------------
  logic [8:0] col_q;
  logic [7:0] row_q;
  logic [9:0] col_inc;
  logic [8:0] row_inc;
  logic [8:0] a_x_q;
  logic [7:0] a_y_q;

  assign col_inc = {1'b0, col_q} + 10'd1;
  assign row_inc = {1'b0, row_q} + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      a_v_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_q <= pix_acc;
      end
      if (pix_acc) begin
        if (col_inc >= {1'b0, eff_width}) begin
          col_q <= '0;
          row_q <= (row_inc >= {1'b0, cfg_height_q}) ? 8'd0 : row_inc[7:0];
        end else begin
          col_q <= col_inc[8:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      a_x_q <= col_q;
      a_y_q <= row_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: centering and row products, color conversion
  // --------------------------------------------------------------------------
  logic [8:0]         scaled_h;
  logic signed [10:0] top_rows;
  logic signed [22:0] b_prod_q;
  logic [18:0]        b_rowp_q;
  logic [8:0]         b_x_q;
  logic [31:0]        b_word_q;
  logic [23:0]        rgb;
  logic               b_load;

  assign b_load   = a_v_q && b_ready;
  assign scaled_h = cfg_dbl_q ? {cfg_height_q, 1'b0} : {1'b0, cfg_height_q};
  assign top_rows = $signed(SCREEN_ROWS) - $signed({2'b00, scaled_h});
  assign rgb      = a_hit_q ? a_rgb_q : 24'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_ready) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_prod_q <= top_rows * $signed({1'b0, cfg_pitch_q});
      b_rowp_q <= a_y_q * cfg_pitch_q;
      b_x_q    <= a_x_q;
      if (mode_bgra) begin
        b_word_q <= {8'd0, rgb};
      end else begin
        b_word_q <= {16'd0, rgb[23:19], rgb[15:10], rgb[7:3]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: output word register, steps through the screen writes
  // --------------------------------------------------------------------------
  logic signed [23:0] base_sum;
  logic signed [23:0] base_adj;
  logic [18:0]        row_term;
  logic [18:0]        col_term;
  logic [18:0]        start_addr;
  logic [2:0]         last_cnt;
  logic [31:0]        c_word_q;
  logic [18:0]        c_dest_q;
  logic [18:0]        c_row_q;
  logic               c_odd_q;
  logic               c_wide_q;
  logic               c_load, c_adv;

  assign base_sum = $signed({b_prod_q[22], b_prod_q}) + $signed({15'd0, center})
                    - $signed({15'd0, eff_width});
  // The QVGA 16-bit mode halves the centering offset, rounding down.
  assign base_adj = mode_one ? (base_sum >>> 1) : base_sum;

  always_comb begin
    if (mode_one) begin
      row_term = cfg_dbl_q ? {b_rowp_q[17:0], 1'b0} : b_rowp_q;
      col_term = {10'd0, b_x_q};
      last_cnt = cfg_dbl_q ? 3'd1 : 3'd0;
    end else begin
      row_term = cfg_dbl_q ? {b_rowp_q[16:0], 2'b00} : {b_rowp_q[17:0], 1'b0};
      col_term = {9'd0, b_x_q, 1'b0};
      last_cnt = cfg_dbl_q ? 3'd7 : 3'd3;
    end
  end

  assign start_addr = base_adj[18:0] + row_term + col_term;
  assign c_load     = c_ready && b_v_q;
  assign c_adv      = c_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q   <= 1'b0;
      c_cnt_q <= '0;
    end else if (c_ready) begin
      c_v_q   <= b_v_q;
      c_cnt_q <= b_v_q ? last_cnt : 3'd0;
    end else if (c_adv) begin
      c_cnt_q <= c_cnt_q - 3'd1;
    end
  end

  // In the wide modes the words go left, right, then down one screen line.
  always_ff @(posedge clk_i) begin
    if (c_load) begin
      c_word_q <= b_word_q;
      c_dest_q <= start_addr;
      c_row_q  <= start_addr;
      c_odd_q  <= 1'b0;
      c_wide_q <= !mode_one;
    end else if (c_adv && !c_ready) begin
      if (c_wide_q && !c_odd_q) begin
        c_dest_q <= c_row_q + 19'd1;
        c_odd_q  <= 1'b1;
      end else begin
        c_dest_q <= c_row_q + {8'd0, cfg_pitch_q};
        c_row_q  <= c_row_q + {8'd0, cfg_pitch_q};
        c_odd_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = c_v_q;
  assign m_axis_tdata  = {5'd0, c_dest_q, c_word_q};
  assign m_axis_tlast  = (c_cnt_q == 3'd0);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A palette write never enters the pixel pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pal_acc) |=> !a_v_q)
    else $error("palette write entered the pixel pipeline");

  // A word that is not the last of its pixel is followed by another word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("pixel ended before its last screen word");

  // In the wide modes the right word sits next to the left one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_v_q && c_wide_q && !c_odd_q && m_axis_tready && !m_axis_tlast) |=>
      (c_odd_q && (c_dest_q == $past(c_dest_q) + 19'd1)))
    else $error("right word of a 2x2 block at the wrong address");

endmodule
